>>> hw/rtl/c3bt_pkg.sv
// ----------------------------------------------------------------------------
// c3bt_pkg
// Shared types, register codes and the tanh table generator for the
// 3x3 convolution block.
// ----------------------------------------------------------------------------
package c3bt_pkg;

  typedef enum logic [2:0] {
    REG_KERNEL_TOP    = 3'd0,
    REG_KERNEL_MIDDLE = 3'd1,
    REG_KERNEL_BOTTOM = 3'd2,
    REG_BIAS          = 3'd3,
    REG_WIDTH         = 3'd4,
    REG_HEIGHT        = 3'd5
  } cfg_reg_e;

  // per-item control that travels down the pipeline
  // row_ok[0] / col_ok[0]: top row / left column of the window lie in frame
  typedef struct packed {
    logic       emit;
    logic       done;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic [7:0] column;
    logic [7:0] row;
  } tag_t;

  localparam longint unsigned OneQ31 = 64'd2147483648;

  // exp(-2^k) in Q1.31, k = -9 .. 2
  localparam longint unsigned ExpNegPow2 [12] = '{
    64'd2143293437, 64'd2139111403, 64'd2130771798, 64'd2114190000,
    64'd2081412523, 64'd2017374191, 64'd1895147668, 64'd1672461947,
    64'd1302514674, 64'd790015084,  64'd290630307,  64'd39332535
  };

  // tanh(4*idx/2^tb) in Q1.15, built from products of exp constants;
  // quotient by restoring subtraction
  function automatic logic [14:0] tanh_entry(input int unsigned idx,
                                             input int unsigned tb);
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    longint unsigned rem;
    longint unsigned dsh;
    logic [16:0]     q;
    e = OneQ31;
    for (int b = 0; b < 12; b++) begin
      if ((b < tb) && (((idx >> b) & 1) != 0)) begin
        e = (e * ExpNegPow2[b + 12 - tb] + 64'd1073741824) >> 31;
      end
    end
    num = (OneQ31 - e) << 15;
    den = OneQ31 + e;
    rem = num + (den >> 1);
    q   = '0;
    for (int k = 16; k >= 0; k--) begin
      dsh = den << k;
      if (rem >= dsh) begin
        rem  = rem - dsh;
        q[k] = 1'b1;
      end
    end
    return (q > 17'd32767) ? 15'h7fff : q[14:0];
  endfunction

endpackage

>>> hw/rtl/c3bt_line_mem.sv
// ----------------------------------------------------------------------------
// c3bt_line_mem
// Line store: one word per column holding the two previous rows. One read
// and one write port, registered read, write-to-read forwarding, and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module c3bt_line_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i,
  output logic                     busy_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] fwd_q;
  logic              hit_q;
  logic              clr_q;
  logic [AW-1:0]     clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      fwd_q <= wr_data_i;
    end
  end

  // same entry written while read: take the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (rd_en_i) begin
      hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = hit_q ? fwd_q : rd_q;
  assign busy_o    = clr_q;

endmodule

>>> hw/rtl/c3bt_seq.sv
// ----------------------------------------------------------------------------
// c3bt_seq
// Input and output position counters: line store column, output decision,
// frame-edge masks and end of frame.
// ----------------------------------------------------------------------------
module c3bt_seq #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height_i,
  output logic [$clog2(MAX_WIDTH)-1:0]      col_o,
  output c3bt_pkg::tag_t                    tag_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0] in_col_q, in_col_d;
  logic [1:0]    in_row_q, in_row_d;
  logic [CW-1:0] em_col_q, em_col_d;
  logic [RW-1:0] em_row_q, em_row_d;

  logic          wrap0;
  logic [CW-1:0] c0;
  logic [1:0]    row1;
  logic [WW-1:0] c1_w;
  logic          last_c;
  logic          emit;
  logic [WW-1:0] em_col_nx;
  logic [HW-1:0] em_row_nx;
  logic          col_end;
  logic          row_end;
  logic [CW+7:0] col_x;
  logic [RW+7:0] row_x;

  always_comb begin
    wrap0     = WW'(in_col_q) >= width_i;
    c0        = wrap0 ? '0 : in_col_q;
    row1      = (wrap0 && in_row_q != 2'd3) ? in_row_q + 2'd1 : in_row_q;
    c1_w      = WW'(c0) + 1'b1;
    last_c    = c1_w >= width_i;
    emit      = (row1 >= 2'd2) || (row1 == 2'd1 && c0 != '0);
    em_col_nx = WW'(em_col_q) + 1'b1;
    em_row_nx = HW'(em_row_q) + 1'b1;
    col_end   = em_col_nx >= width_i;
    row_end   = em_row_nx >= height_i;
    col_x     = {8'b0, em_col_q};
    row_x     = {8'b0, em_row_q};

    tag_o.emit   = emit;
    tag_o.done   = row_end && col_end;
    tag_o.row_ok = {!row_end, 1'b1, em_row_q != '0};
    tag_o.col_ok = {!col_end, 1'b1, em_col_q != '0};
    tag_o.column = col_x[7:0];
    tag_o.row    = row_x[7:0];

    in_col_d = last_c ? '0 : c1_w[CW-1:0];
    in_row_d = (last_c && row1 != 2'd3) ? row1 + 2'd1 : row1;
    em_col_d = em_col_q;
    em_row_d = em_row_q;
    if (emit) begin
      if (row_end && col_end) begin
        in_col_d = '0;
        in_row_d = '0;
        em_col_d = '0;
        em_row_d = '0;
      end else if (col_end) begin
        em_col_d = '0;
        em_row_d = em_row_nx[RW-1:0];
      end else begin
        em_col_d = em_col_nx[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      em_col_q <= '0;
      em_row_q <= '0;
    end else if (accept_i) begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      em_col_q <= em_col_d;
      em_row_q <= em_row_d;
    end
  end

  assign col_o = c0;

endmodule

>>> hw/rtl/c3bt_mac.sv
// ----------------------------------------------------------------------------
// c3bt_mac
// 3x3 window, masked weights, nine products and a two-level adder tree
// with the bias.
// ----------------------------------------------------------------------------
module c3bt_mac #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  c3bt_pkg::tag_t                tag_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] older_i,
  input  logic signed [SAMPLE_BITS-1:0] newer_i,
  input  logic [47:0]                   kernel_top_i,
  input  logic [47:0]                   kernel_mid_i,
  input  logic [47:0]                   kernel_bot_i,
  input  logic signed [15:0]            bias_i,
  output logic                          valid_o,
  output c3bt_pkg::tag_t                tag_o,
  output logic signed [SAMPLE_BITS+19:0] acc_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned PW    = SB + 16;
  localparam int unsigned ACC_W = SB + 20;

  logic signed [SB-1:0]    win_q [9];
  logic [47:0]             krow [3];
  logic signed [15:0]      wgt [9];
  logic signed [PW-1:0]    prod_d [9];
  logic signed [PW-1:0]    prod_q [9];
  logic signed [ACC_W-1:0] sum_q [3];
  logic signed [ACC_W-1:0] acc_q;

  logic           p2_v_q, p3_v_q, p4_v_q, p5_v_q;
  c3bt_pkg::tag_t p2_tag_q, p3_tag_q, p4_tag_q, p5_tag_q;

  assign krow[0] = kernel_top_i;
  assign krow[1] = kernel_mid_i;
  assign krow[2] = kernel_bot_i;

  // window shifts left; new column from the line store and the input
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (en_i && valid_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]     <= win_q[r*3 + 1];
        win_q[r*3 + 1] <= win_q[r*3 + 2];
      end
      win_q[2] <= older_i;
      win_q[5] <= newer_i;
      win_q[8] <= sample_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        wgt[r*3 + c] = (p2_tag_q.row_ok[r] && p2_tag_q.col_ok[c]) ?
                       signed'(krow[r][16*c +: 16]) : '0;
      end
    end
    for (int i = 0; i < 9; i++) begin
      prod_d[i] = PW'(win_q[i]) * PW'(wgt[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
    end else if (en_i) begin
      p2_v_q <= valid_i && tag_i.emit;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
      p5_v_q <= p4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p2_tag_q <= tag_i;
      p3_tag_q <= p2_tag_q;
      p4_tag_q <= p3_tag_q;
      p5_tag_q <= p4_tag_q;
      for (int i = 0; i < 9; i++) begin
        prod_q[i] <= prod_d[i];
      end
      sum_q[0] <= ACC_W'(prod_q[0]) + ACC_W'(prod_q[1]) + ACC_W'(prod_q[2])
                + (ACC_W'(bias_i) <<< (SB - 1));
      sum_q[1] <= ACC_W'(prod_q[3]) + ACC_W'(prod_q[4]) + ACC_W'(prod_q[5]);
      sum_q[2] <= ACC_W'(prod_q[6]) + ACC_W'(prod_q[7]) + ACC_W'(prod_q[8]);
      acc_q    <= sum_q[0] + sum_q[1] + sum_q[2];
    end
  end

  assign valid_o = p5_v_q;
  assign tag_o   = p5_tag_q;
  assign acc_o   = acc_q;

endmodule

>>> hw/rtl/c3bt_act.sv
// ----------------------------------------------------------------------------
// c3bt_act
// Saturating tanh: magnitude, rounded table index, registered table read,
// sign restore.
// ----------------------------------------------------------------------------
module c3bt_act #(
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned TANH_TABLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  c3bt_pkg::tag_t                 tag_i,
  input  logic signed [SAMPLE_BITS+19:0] acc_i,
  output logic                           valid_o,
  output c3bt_pkg::tag_t                 tag_o,
  output logic [15:0]                    act_o
);

  localparam int unsigned ACC_W = SAMPLE_BITS + 20;
  localparam int unsigned TB    = TANH_TABLE_BITS;
  localparam int unsigned SH    = SAMPLE_BITS + 13 - TANH_TABLE_BITS;
  localparam logic [ACC_W:0] RndHalf = (ACC_W + 1)'(1) << (SH - 1);

  logic [14:0] rom [2**TB];

  for (genvar g = 0; g < 2**TB; g++) begin : g_rom
    localparam logic [14:0] Entry = c3bt_pkg::tanh_entry(g, TB);
    assign rom[g] = Entry;
  end

  logic             neg;
  logic [ACC_W-1:0] mag;
  logic [ACC_W:0]   rnd;

  logic             p5_v_q, p6_v_q;
  c3bt_pkg::tag_t   p5_tag_q, p6_tag_q;
  logic [TB-1:0]    idx_q;
  logic             sat_q, sat6_q;
  logic             neg_q, neg6_q;
  logic [14:0]      rom_q;
  logic [15:0]      mag_out;

  always_comb begin
    neg = acc_i[ACC_W-1];
    mag = neg ? ACC_W'(-acc_i) : ACC_W'(acc_i);
    rnd = {1'b0, mag} + RndHalf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_v_q <= 1'b0;
      p6_v_q <= 1'b0;
    end else if (en_i) begin
      p5_v_q <= valid_i;
      p6_v_q <= p5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p5_tag_q <= tag_i;
      idx_q    <= rnd[SH+TB-1:SH];
      sat_q    <= |rnd[ACC_W:SH+TB];
      neg_q    <= neg;
      p6_tag_q <= p5_tag_q;
      rom_q    <= rom[idx_q];
      sat6_q   <= sat_q;
      neg6_q   <= neg_q;
    end
  end

  assign mag_out = sat6_q ? 16'h7fff : {1'b0, rom_q};
  assign act_o   = neg6_q ? 16'(-mag_out) : mag_out;
  assign valid_o = p6_v_q;
  assign tag_o   = p6_tag_q;

endmodule

>>> hw/rtl/conv3x3_bias_tanh.sv
// ----------------------------------------------------------------------------
// conv3x3_bias_tanh
// 3x3 convolution over a raster-order frame with zero padding, bias and a
// saturating tanh. Line store in one dual-row memory.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                   tuser / tlast
//  s_axis    in   sample                               tuser: is_padding
//  m_axis    out  activation, out_column, out_row      tlast: frame_done
//  cfg       in   write enable, index 0..5, 48b data   -
//
// One word per clock sustained while s_axis_tready stays high. A result of the
// word that completes its window passes the read stage, the window, product,
// sum, accumulator, table index and table read registers to the output register;
// the first result of a frame follows width+1 words. After reset the line store
// is cleared with s_axis_tready low. s_axis_tready drops while the output skid
// slot is occupied or while the line store is being cleared.
module conv3x3_bias_tanh #(
  parameter int unsigned MAX_WIDTH       = 256,
  parameter int unsigned MAX_HEIGHT      = 256,
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned TANH_TABLE_BITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample
  input  logic                                 s_axis_tuser,  // is_padding
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [31:0]                          m_axis_tdata,  // activation, out_column, out_row
  output logic                                 m_axis_tlast,  // frame_done
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_idx_i,
  input  logic [47:0]                          cfg_data_i
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WRst  = (MAX_WIDTH < 160) ? MAX_WIDTH : 160;
  localparam int unsigned HRst  = (MAX_HEIGHT < 240) ? MAX_HEIGHT : 240;

  // configuration
  logic [47:0]        ktop_q, kmid_q, kbot_q;
  logic signed [15:0] bias_q;
  logic [WW-1:0]      width_q;
  logic [HW-1:0]      height_q;
  logic [15:0]        size_v;
  logic [15:0]        width_cl;
  logic [15:0]        height_cl;

  always_comb begin
    size_v    = {7'b0, cfg_data_i[8:0]};
    width_cl  = (size_v == '0) ? 16'd1 :
                (size_v > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : size_v;
    height_cl = (size_v == '0) ? 16'd1 :
                (size_v > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT) : size_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ktop_q   <= '0;
      kmid_q   <= '0;
      kbot_q   <= '0;
      bias_q   <= '0;
      width_q  <= WW'(WRst);
      height_q <= HW'(HRst);
    end else if (cfg_we_i) begin
      case (c3bt_pkg::cfg_reg_e'(cfg_idx_i))
        c3bt_pkg::REG_KERNEL_TOP:    ktop_q   <= cfg_data_i;
        c3bt_pkg::REG_KERNEL_MIDDLE: kmid_q   <= cfg_data_i;
        c3bt_pkg::REG_KERNEL_BOTTOM: kbot_q   <= cfg_data_i;
        c3bt_pkg::REG_BIAS:          bias_q   <= cfg_data_i[15:0];
        c3bt_pkg::REG_WIDTH:         width_q  <= width_cl[WW-1:0];
        c3bt_pkg::REG_HEIGHT:        height_q <= height_cl[HW-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic skid_v_q;
  logic en;
  logic busy;
  logic accept;

  assign en            = !skid_v_q;
  assign s_axis_tready = en && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // position
  logic [CW-1:0]  rd_col;
  c3bt_pkg::tag_t in_tag;

  c3bt_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .width_i  (width_q),
    .height_i (height_q),
    .col_o    (rd_col),
    .tag_o    (in_tag)
  );

  // line store read stage
  logic                 p1_v_q;
  c3bt_pkg::tag_t       p1_tag_q;
  logic signed [SB-1:0] p1_s_q;
  logic [CW-1:0]        p1_col_q;
  logic [2*SB-1:0]      rd_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_tag_q <= in_tag;
      p1_s_q   <= s_axis_tuser ? '0 : s_axis_tdata[SB-1:0];
      p1_col_q <= rd_col;
    end
  end

  c3bt_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * SB)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_col),
    .rd_data_o (rd_word),
    .wr_en_i   (en && p1_v_q),
    .wr_addr_i (p1_col_q),
    .wr_data_i ({rd_word[SB-1:0], p1_s_q}),
    .busy_o    (busy)
  );

  // arithmetic
  logic                    mac_v;
  c3bt_pkg::tag_t          mac_tag;
  logic signed [SB+19:0]   mac_acc;

  c3bt_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (p1_v_q),
    .tag_i        (p1_tag_q),
    .sample_i     (p1_s_q),
    .older_i      (rd_word[2*SB-1:SB]),
    .newer_i      (rd_word[SB-1:0]),
    .kernel_top_i (ktop_q),
    .kernel_mid_i (kmid_q),
    .kernel_bot_i (kbot_q),
    .bias_i       (bias_q),
    .valid_o      (mac_v),
    .tag_o        (mac_tag),
    .acc_o        (mac_acc)
  );

  logic           res_v;
  c3bt_pkg::tag_t res_tag;
  logic [15:0]    res_act;

  c3bt_act #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .TANH_TABLE_BITS (TANH_TABLE_BITS)
  ) u_act (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mac_v),
    .tag_i   (mac_tag),
    .acc_i   (mac_acc),
    .valid_o (res_v),
    .tag_o   (res_tag),
    .act_o   (res_act)
  );

  // output register and skid slot
  logic        out_v_q;
  logic [32:0] out_q;
  logic [32:0] skid_q;
  logic [32:0] res_word;
  logic        take;
  logic        res_new;

  assign res_word = {res_tag.done, res_tag.row, res_tag.column, res_act};
  assign take     = out_v_q && m_axis_tready;
  assign res_new  = en && res_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (res_new) begin
      if (out_v_q && !take) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (res_new) begin
      if (out_v_q && !take) begin
        skid_q <= res_word;
      end else begin
        out_q <= res_word;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q[31:0];
  assign m_axis_tlast  = out_q[32];

endmodule

>>> bench/conv3x3_bias_tanh_tb.sv
// ----------------------------------------------------------------------------
// conv3x3_bias_tanh_tb
// Streams small frames of Q1.15 pixels through the 3x3 convolution block
// under changing kernels, bias and frame sizes; every output word is checked
// against a given word or a model of window, line stores and tanh table.
// ----------------------------------------------------------------------------
module conv3x3_bias_tanh_tb;

  localparam int HALF_PERIOD   = 5;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MAX_DIM       = 256;
  localparam int LUT_SIZE      = 1024;
  localparam int HOLD_CYCLES   = 300;

  localparam longint unsigned Q31_ONE = 64'd2147483648;
  // exp(-2^k) in Q1.31, k = -7 .. 2
  localparam longint unsigned ExpNegQ31 [10] = '{
    64'd2130771798, 64'd2114190000, 64'd2081412523, 64'd2017374191,
    64'd1895147668, 64'd1672461947, 64'd1302514674, 64'd790015084,
    64'd290630307,  64'd39332535
  };

  typedef struct packed {
    logic [15:0] act;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        done;
  } px_t;

  typedef enum logic {STEP_CFG, STEP_WORD} step_kind_e;

  typedef struct {
    step_kind_e           kind;
    c3bt_pkg::cfg_reg_e   reg_idx;
    logic [47:0]          value;
    logic [15:0]          smp;
    logic                 pad;
    bit                   typed;
    px_t                  want;
  } plan_step_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // sample
  logic        s_axis_tuser  = 1'b0; // is_padding
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // activation, out_column, out_row
  logic        m_axis_tlast;         // frame_done
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [47:0] cfg_data_i    = '0;

  conv3x3_bias_tanh u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // model state
  logic [47:0]        kern [3];
  logic signed [15:0] bias_q;
  logic [8:0]         width_q;
  logic [8:0]         height_q;
  logic signed [15:0] line_old [MAX_DIM];
  logic signed [15:0] line_new [MAX_DIM];
  logic signed [15:0] win [9];
  logic [15:0]        tanh_lut [LUT_SIZE];
  int                 col_in, row_in, col_out, row_out;

  px_t        expected_px [$];
  plan_step_t plan [$];
  int         items_sent    = 0;
  int         err_count     = 0;
  int         src_idle_pct  = 0;
  int         sink_idle_pct = 0;
  int         hold_request  = 0;

  task automatic report_err(input string msg);
    err_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int eff_size(input logic [8:0] v);
    if (v == 9'd0) return 1;
    if (v > 9'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [15:0] tanh_q15(input longint acc);
    longint unsigned mag;
    longint unsigned idx;
    logic [15:0]     t;
    mag = (acc < 0) ? longint'(-acc) : longint'(acc);
    idx = (mag + (64'd1 << 18)) >> 19;
    t   = (idx >= LUT_SIZE) ? 16'h7fff : tanh_lut[idx];
    return (acc < 0) ? -t : t;
  endfunction

  // one accepted word through the window; returns 1 when a pixel comes out
  function automatic bit convolve_pixel(input logic [15:0] smp, input logic pad,
                                        output px_t res);
    int                 w, h;
    logic signed [15:0] s;
    logic signed [15:0] wt;
    bit                 fire, done;
    bit                 rok [3];
    bit                 cok [3];
    longint             acc;
    w = eff_size(width_q);
    h = eff_size(height_q);
    s = pad ? 16'sd0 : smp;
    res = '0;
    if (col_in >= w) begin
      col_in = 0;
      if (row_in < 511) row_in++;
    end
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = line_old[col_in];
    win[5] = line_new[col_in];
    win[8] = s;
    line_old[col_in] = line_new[col_in];
    line_new[col_in] = s;
    fire = (row_in >= 2) || (row_in == 1 && col_in >= 1);
    if (col_in + 1 >= w) begin
      col_in = 0;
      if (row_in < 511) row_in++;
    end else begin
      col_in++;
    end
    if (!fire) return 1'b0;

    acc = longint'(bias_q) * 32768;
    rok[0] = row_out > 0; rok[1] = 1'b1; rok[2] = row_out + 1 < h;
    cok[0] = col_out > 0; cok[1] = 1'b1; cok[2] = col_out + 1 < w;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rok[r] && cok[c]) begin
          wt  = kern[r][16*c +: 16];
          acc += longint'(wt) * longint'(win[r*3+c]);
        end
      end
    end
    done = (row_out + 1 >= h) && (col_out + 1 >= w);
    res.act  = tanh_q15(acc);
    res.col  = col_out[7:0];
    res.row  = row_out[7:0];
    res.done = done;
    if (done) begin
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    end else if (col_out + 1 >= w) begin
      col_out = 0;
      row_out++;
    end else begin
      col_out++;
    end
    return 1'b1;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input c3bt_pkg::cfg_reg_e idx, input logic [47:0] val);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      c3bt_pkg::REG_KERNEL_TOP:    kern[0] = val;
      c3bt_pkg::REG_KERNEL_MIDDLE: kern[1] = val;
      c3bt_pkg::REG_KERNEL_BOTTOM: kern[2] = val;
      c3bt_pkg::REG_BIAS:          bias_q = val[15:0];
      c3bt_pkg::REG_WIDTH:         width_q = val[8:0];
      c3bt_pkg::REG_HEIGHT:        height_q = val[8:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic [15:0] smp, input logic pad,
                           input bit given, input px_t want);
    px_t res;
    bit  fired;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= pad;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    fired = convolve_pixel(smp, pad, res);
    if (given) expected_px.push_back(want);
    else if (fired) expected_px.push_back(res);
  endtask

  function automatic void plan_cfg(input c3bt_pkg::cfg_reg_e idx,
                                   input logic [47:0] val);
    plan_step_t st;
    st.kind = STEP_CFG; st.reg_idx = idx; st.value = val;
    st.smp = '0; st.pad = 1'b0; st.typed = 1'b0; st.want = '0;
    plan.push_back(st);
  endfunction

  function automatic void plan_word(input logic [15:0] smp, input logic pad,
                                    input bit typed, input logic [15:0] act,
                                    input logic [7:0] col, input logic [7:0] row,
                                    input logic done);
    plan_step_t st;
    st.kind = STEP_WORD; st.reg_idx = c3bt_pkg::REG_KERNEL_TOP; st.value = '0;
    st.smp = smp; st.pad = pad; st.typed = typed;
    st.want = '{act: act, col: col, row: row, done: done};
    plan.push_back(st);
  endfunction

  function automatic logic [15:0] rand_weight();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  function automatic logic [8:0] rand_dim(input int hi);
    if ($urandom_range(0, 19) == 0) return 9'd0;
    return 9'($urandom_range(1, hi));
  endfunction

  // new settings, then one frame: mostly well formed, some short or long on
  // padding, some pure noise
  task automatic run_frame(input logic [8:0] wreg, input logic [8:0] hreg,
                           input bit tidy);
    int w, h, shape, n_pad;
    write_reg(c3bt_pkg::REG_KERNEL_TOP,
              {rand_weight(), rand_weight(), rand_weight()});
    write_reg(c3bt_pkg::REG_KERNEL_MIDDLE,
              {rand_weight(), rand_weight(), rand_weight()});
    write_reg(c3bt_pkg::REG_KERNEL_BOTTOM,
              {rand_weight(), rand_weight(), rand_weight()});
    write_reg(c3bt_pkg::REG_BIAS,   {32'd0, rand_weight()});
    write_reg(c3bt_pkg::REG_WIDTH,  {39'd0, wreg});
    write_reg(c3bt_pkg::REG_HEIGHT, {39'd0, hreg});
    w = eff_size(wreg);
    h = eff_size(hreg);
    shape = tidy ? 0 : $urandom_range(0, 9);
    if (shape == 9) begin
      repeat ($urandom_range(1, 3*w + 3))
        send_word(16'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
    end else begin
      repeat (w*h) send_word(16'($urandom), $urandom_range(0, 15) == 0, 1'b0, '0);
      case (shape)
        7:       n_pad = $urandom_range(0, w);
        8:       n_pad = w + 1 + $urandom_range(1, w + 2);
        default: n_pad = w + 1;
      endcase
      repeat (n_pad) send_word(16'($urandom), 1'b1, 1'b0, '0);
    end
  endtask

  // output side: check, then pick tready for the next cycle
  always @(posedge clk_i) begin : sink
    px_t got;
    px_t want;
    int  hold_left;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{act: m_axis_tdata[15:0], col: m_axis_tdata[23:16],
              row: m_axis_tdata[31:24], done: m_axis_tlast};
      if (expected_px.size() == 0) begin
        report_err($sformatf("unexpected word act=%h col=%0d row=%0d done=%b",
                             got.act, got.col, got.row, got.done));
      end else begin
        want = expected_px.pop_front();
        if (got !== want)
          report_err($sformatf("word mismatch: got act=%h col=%0d row=%0d done=%b, want act=%h col=%0d row=%0d done=%b",
                               got.act, got.col, got.row, got.done,
                               want.act, want.col, want.row, want.done));
      end
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    int quiet_cycles;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("conv3x3_bias_tanh test failed");
        $finish;
      end
    end
  end

  initial begin
    longint unsigned e, num, den, q;
    int              stop_at;

    for (int i = 0; i < LUT_SIZE; i++) begin
      e = Q31_ONE;
      for (int b = 0; b < 10; b++)
        if (i[b]) e = (e * ExpNegQ31[b] + (64'd1 << 30)) >> 31;
      num = (Q31_ONE - e) << 15;
      den = Q31_ONE + e;
      q   = (num + den / 2) / den;
      tanh_lut[i] = (q > 32767) ? 16'h7fff : q[15:0];
    end
    for (int i = 0; i < MAX_DIM; i++) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    foreach (kern[i]) kern[i] = '0;
    bias_q = '0; width_q = 9'd160; height_q = 9'd240;
    col_in = 0; row_in = 0; col_out = 0; row_out = 0;

    // zero kernel and bias after reset: every pixel of a 3x2 frame is zero;
    // extremes of the sample and padding inside the frame
    plan_cfg(c3bt_pkg::REG_WIDTH,  48'd3);
    plan_cfg(c3bt_pkg::REG_HEIGHT, 48'd2);
    plan_word(16'h7fff, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'h8000, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'h0000, 1'b1, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'hffff, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'h0001, 1'b0, 1'b1, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'h5555, 1'b0, 1'b1, 16'h0000, 8'd1, 8'd0, 1'b0);
    plan_word(16'h0000, 1'b1, 1'b1, 16'h0000, 8'd2, 8'd0, 1'b0);
    plan_word(16'h0000, 1'b1, 1'b1, 16'h0000, 8'd0, 8'd1, 1'b0);
    plan_word(16'h0000, 1'b1, 1'b1, 16'h0000, 8'd1, 8'd1, 1'b0);
    plan_word(16'h0000, 1'b1, 1'b1, 16'h0000, 8'd2, 8'd1, 1'b1);
    // zero sizes act as 1x1; largest bias saturates high
    plan_cfg(c3bt_pkg::REG_BIAS,   48'h7fff);
    plan_cfg(c3bt_pkg::REG_WIDTH,  48'd0);
    plan_cfg(c3bt_pkg::REG_HEIGHT, 48'd0);
    plan_word(16'h8000, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'h0000, 1'b1, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'h0000, 1'b1, 1'b1, 16'h7fff, 8'd0, 8'd0, 1'b1);
    // most negative bias saturates low
    plan_cfg(c3bt_pkg::REG_BIAS,   48'h8000);
    plan_word(16'h7fff, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'h0000, 1'b1, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'h0000, 1'b1, 1'b1, 16'h8001, 8'd0, 8'd0, 1'b1);
    // extreme weights on a 2x2 frame
    plan_cfg(c3bt_pkg::REG_KERNEL_TOP,    48'h0001_7fff_8000);
    plan_cfg(c3bt_pkg::REG_KERNEL_MIDDLE, 48'h1000_f000_1000);
    plan_cfg(c3bt_pkg::REG_KERNEL_BOTTOM, 48'h8000_0000_7fff);
    plan_cfg(c3bt_pkg::REG_BIAS,          48'h0123);
    plan_cfg(c3bt_pkg::REG_WIDTH,         48'd2);
    plan_cfg(c3bt_pkg::REG_HEIGHT,        48'd2);
    plan_word(16'h7fff, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'h8000, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'h1234, 1'b1, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    plan_word(16'h0001, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);
    repeat (3) plan_word(16'h0000, 1'b1, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct  = 9;
    sink_idle_pct = 68;
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) write_reg(plan[i].reg_idx, plan[i].value);
      else send_word(plan[i].smp, plan[i].pad, plan[i].typed, plan[i].want);
    end

    for (int regime = 0; regime < 3; regime++) begin
      src_idle_pct  = (regime == 0) ? 9  : (regime == 1) ? 68 : 0;
      sink_idle_pct = (regime == 0) ? 68 : (regime == 1) ? 9  : 0;
      if (regime == 2) begin
        // back-pressure long enough to fill the pipe and stall the input
        hold_request = HOLD_CYCLES;
        run_frame(9'd8, 9'd6, 1'b1);
        run_frame(9'h1ff, 9'd1, 1'b1);
      end
      stop_at = items_sent + 80;
      while (items_sent < stop_at) run_frame(rand_dim(10), rand_dim(8), 1'b0);
    end

    wait_drained();
    if (err_count == 0) begin
      $display("conv3x3_bias_tanh test passed");
    end else begin
      $display("conv3x3_bias_tanh test failed");
    end
    $finish;
  end

endmodule
